@@ sv/icr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_pkg
// Shared codes and types of the input change recorder and replayer.
// ----------------------------------------------------------------------------
package icr_pkg;

  // Operating modes; the unused code behaves as off.
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_RECORD   = 2'd1;
  localparam logic [1:0] MODE_PLAYBACK = 2'd2;

  // Item kinds
  localparam logic ACT_TICK     = 1'b0;
  localparam logic ACT_SET_MODE = 1'b1;

  // Values of the last logged input after a restart
  localparam logic [7:0]  LAST_BYTE_INIT = 8'hff;
  localparam logic [15:0] LAST_KEY_INIT  = 16'hffff;

  // One result word
  typedef struct packed {
    logic [7:0]  pos;
    logic [7:0]  button;
    logic [15:0] key;
    logic        logged;
    logic        replayed;
    logic        full;
  } icr_result_t;

endpackage

@@ sv/input_change_recorder_replayer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_change_recorder_replayer
// Records changes of joystick and key input with their frame number and
// replays them frame-accurately.
// ----------------------------------------------------------------------------
// Takes one word per clock unless out_stall holds it and returns one result
// word for each in the cycle after acceptance; the output register lets a
// new word in while a result waits, as long as that result is taken in the
// same cycle. The log store does one write (record) or one prefetched read
// (playback) per word, which sets the rate at one word per cycle. No
// clearing pass follows reset: a high-water mark of written entries makes
// unwritten entries read as zero, so words are accepted right after reset.
module input_change_recorder_replayer #(
  parameter int LOG_DEPTH  = 1024,
  parameter int FRAME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_new_mode,
  input  logic [7:0]  in_joystick_pos,
  input  logic [7:0]  in_joystick_button,
  input  logic [15:0] in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_joystick_pos_out,
  output logic [7:0]  out_joystick_button_out,
  output logic [15:0] out_key_out,
  output logic        out_entry_logged,
  output logic        out_entry_replayed,
  output logic        out_log_full
);

  logic                accept;
  logic                out_valid_r;
  icr_pkg::icr_result_t res;
  icr_pkg::icr_result_t res_r;

  // Hold input while a result waits and the far side stalls
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  icr_ctrl #(
    .LOG_DEPTH  (LOG_DEPTH),
    .FRAME_BITS (FRAME_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .action          (in_action),
    .new_mode        (in_new_mode),
    .joystick_pos    (in_joystick_pos),
    .joystick_button (in_joystick_button),
    .key_code        (in_key_code),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_joystick_pos_out    = res_r.pos;
  assign out_joystick_button_out = res_r.button;
  assign out_key_out             = res_r.key;
  assign out_entry_logged        = res_r.logged;
  assign out_entry_replayed      = res_r.replayed;
  assign out_log_full            = res_r.full;

endmodule

@@ sv/icr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/icr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_ctrl
// Mode, frame and log index state, change detection, replay match and the
// log store with its prefetched read.
// ----------------------------------------------------------------------------
module icr_ctrl #(
  parameter int LOG_DEPTH  = 1024,
  parameter int FRAME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                action,
  input  logic [1:0]          new_mode,
  input  logic [7:0]          joystick_pos,
  input  logic [7:0]          joystick_button,
  input  logic [15:0]         key_code,
  output icr_pkg::icr_result_t res
);

  localparam int ADDR_W  = $clog2(LOG_DEPTH);
  localparam int IDX_W   = $clog2(LOG_DEPTH + 1);
  localparam int ENTRY_W = 32 + FRAME_BITS;
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(LOG_DEPTH);

  logic [1:0]            mode_r, mode_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      hwm_r, hwm_nxt;
  logic [7:0]            last_pos_r, last_pos_nxt;
  logic [7:0]            last_btn_r, last_btn_nxt;
  logic [15:0]           last_key_r, last_key_nxt;
  logic [7:0]            held_pos_r, held_pos_nxt;
  logic [7:0]            held_btn_r, held_btn_nxt;
  logic                  hit_r;

  logic                  mem_we;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic [ENTRY_W-1:0]    mem_rdata;
  logic [ENTRY_W-1:0]    entry;
  logic [IDX_W-1:0]      rd_idx;
  logic                  full;
  logic                  changed;

  logic [7:0]            e_pos;
  logic [7:0]            e_btn;
  logic [15:0]           e_key;
  logic [FRAME_BITS-1:0] e_frame;

  // Entries at or above the high-water mark were never written: read as zero
  assign entry = hit_r ? mem_rdata : '0;
  assign {e_pos, e_btn, e_key, e_frame} = entry;

  assign full      = (idx_r >= DEPTH_IDX);
  assign changed   = (joystick_pos != last_pos_r) || (joystick_button != last_btn_r) ||
                     (key_code != last_key_r);
  assign mem_wdata = {joystick_pos, joystick_button, key_code, frame_r};

  always_comb begin
    mode_nxt     = mode_r;
    frame_nxt    = frame_r;
    idx_nxt      = idx_r;
    hwm_nxt      = hwm_r;
    last_pos_nxt = last_pos_r;
    last_btn_nxt = last_btn_r;
    last_key_nxt = last_key_r;
    held_pos_nxt = held_pos_r;
    held_btn_nxt = held_btn_r;
    mem_we       = 1'b0;
    res.pos      = joystick_pos;
    res.button   = joystick_button;
    res.key      = key_code;
    res.logged   = 1'b0;
    res.replayed = 1'b0;

    if (action == icr_pkg::ACT_SET_MODE) begin
      mode_nxt     = new_mode;
      frame_nxt    = '0;
      idx_nxt      = '0;
      last_pos_nxt = icr_pkg::LAST_BYTE_INIT;
      last_btn_nxt = icr_pkg::LAST_BYTE_INIT;
      last_key_nxt = icr_pkg::LAST_KEY_INIT;
      held_pos_nxt = '0;
      held_btn_nxt = '0;
    end else begin
      case (mode_r)
        icr_pkg::MODE_RECORD: begin
          if (changed && !full) begin
            mem_we       = accept;
            last_pos_nxt = joystick_pos;
            last_btn_nxt = joystick_button;
            last_key_nxt = key_code;
            idx_nxt      = idx_r + 1'b1;
            res.logged   = 1'b1;
            if (idx_nxt > hwm_r) begin
              hwm_nxt = idx_nxt;
            end
          end
        end
        icr_pkg::MODE_PLAYBACK: begin
          if (!full) begin
            if (e_frame == frame_r) begin
              held_pos_nxt = e_pos;
              held_btn_nxt = e_btn;
              res.key      = e_key;
              idx_nxt      = idx_r + 1'b1;
              res.replayed = 1'b1;
            end
            res.pos    = held_pos_nxt;
            res.button = held_btn_nxt;
          end
        end
        default: begin
        end
      endcase
      frame_nxt = frame_r + 1'b1;
    end
    res.full = (idx_nxt >= DEPTH_IDX);
  end

  // Prefetch the entry the next item will look at
  assign rd_idx = accept ? idx_nxt : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= icr_pkg::MODE_OFF;
      frame_r    <= '0;
      idx_r      <= '0;
      hwm_r      <= '0;
      last_pos_r <= icr_pkg::LAST_BYTE_INIT;
      last_btn_r <= icr_pkg::LAST_BYTE_INIT;
      last_key_r <= icr_pkg::LAST_KEY_INIT;
      held_pos_r <= '0;
      held_btn_r <= '0;
      hit_r      <= 1'b0;
    end else begin
      if (accept) begin
        mode_r     <= mode_nxt;
        frame_r    <= frame_nxt;
        idx_r      <= idx_nxt;
        hwm_r      <= hwm_nxt;
        last_pos_r <= last_pos_nxt;
        last_btn_r <= last_btn_nxt;
        last_key_r <= last_key_nxt;
        held_pos_r <= held_pos_nxt;
        held_btn_r <= held_btn_nxt;
      end
      hit_r <= (rd_idx < hwm_r);
    end
  end

  icr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r[ADDR_W-1:0]),
    .wdata (mem_wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= DEPTH_IDX)
    else $error("log index beyond log depth");

  a_write_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mode_r == icr_pkg::MODE_RECORD) && !full)
    else $error("log write outside record mode or into a full log");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(res.logged && res.replayed))
    else $error("tick both logged and replayed");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (action == icr_pkg::ACT_SET_MODE) |=> (idx_r == '0) && (frame_r == '0))
    else $error("set-mode did not restart index and frame");
`endif

endmodule

@@ tb/sv/input_change_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_change_checker
// Watches both channels of the input change recorder and replayer. It keeps
// its own copy of the mode, frame count, log index, last logged input, held
// replay values and the log store. It works out the result word of every
// accepted input word and compares the returned words with them in order.
// ----------------------------------------------------------------------------
module input_change_checker #(
  parameter int LOG_DEPTH  = 1024,
  parameter int FRAME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_new_mode,
  input  logic [7:0]  in_joystick_pos,
  input  logic [7:0]  in_joystick_button,
  input  logic [15:0] in_key_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_joystick_pos_out,
  input  logic [7:0]  out_joystick_button_out,
  input  logic [15:0] out_key_out,
  input  logic        out_entry_logged,
  input  logic        out_entry_replayed,
  input  logic        out_log_full,
  output int          mismatches,
  output int          awaited_count,
  output int          logged_count,
  output int          replayed_count,
  output int          full_count
);

  localparam int IDX_W  = $clog2(LOG_DEPTH + 1);
  localparam int ADDR_W = $clog2(LOG_DEPTH);

  logic [1:0]            mode_now;
  logic [FRAME_BITS-1:0] frame_now;
  logic [IDX_W-1:0]      idx_now;
  logic [7:0]            last_pos;
  logic [7:0]            last_button;
  logic [15:0]           last_key;
  logic [7:0]            held_pos;
  logic [7:0]            held_button;

  logic [7:0]            tape_pos    [LOG_DEPTH];
  logic [7:0]            tape_button [LOG_DEPTH];
  logic [15:0]           tape_key    [LOG_DEPTH];
  logic [FRAME_BITS-1:0] tape_frame  [LOG_DEPTH];

  icr_pkg::icr_result_t awaited_words[$];

  int fail_tally     = 0;
  int results_seen   = 0;
  int logged_tally   = 0;
  int replayed_tally = 0;
  int full_tally     = 0;

  function automatic void restart_session(input logic [1:0] m);
    mode_now    = m;
    frame_now   = '0;
    idx_now     = '0;
    last_pos    = icr_pkg::LAST_BYTE_INIT;
    last_button = icr_pkg::LAST_BYTE_INIT;
    last_key    = icr_pkg::LAST_KEY_INIT;
    held_pos    = '0;
    held_button = '0;
  endfunction

  // Work out the result of one word and advance the copy of the state.
  function automatic icr_pkg::icr_result_t replay_result(input logic act,
                                                         input logic [1:0] nm,
                                                         input logic [7:0] p,
                                                         input logic [7:0] b,
                                                         input logic [15:0] k);
    icr_pkg::icr_result_t r;
    logic [ADDR_W-1:0] slot;
    slot       = idx_now[ADDR_W-1:0];
    r.pos      = p;
    r.button   = b;
    r.key      = k;
    r.logged   = 1'b0;
    r.replayed = 1'b0;
    if (act == icr_pkg::ACT_SET_MODE) begin
      restart_session(nm);
    end else begin
      if (mode_now == icr_pkg::MODE_RECORD) begin
        if ({p, b, k} != {last_pos, last_button, last_key} && idx_now < LOG_DEPTH) begin
          tape_pos[slot]    = p;
          tape_button[slot] = b;
          tape_key[slot]    = k;
          tape_frame[slot]  = frame_now;
          last_pos    = p;
          last_button = b;
          last_key    = k;
          idx_now     = idx_now + 1'b1;
          r.logged    = 1'b1;
        end
      end else if (mode_now == icr_pkg::MODE_PLAYBACK && idx_now < LOG_DEPTH) begin
        if (tape_frame[slot] == frame_now) begin
          held_pos    = tape_pos[slot];
          held_button = tape_button[slot];
          r.key       = tape_key[slot];
          idx_now     = idx_now + 1'b1;
          r.replayed  = 1'b1;
        end
        r.pos    = held_pos;
        r.button = held_button;
      end
      frame_now = frame_now + 1'b1;
    end
    r.full = (idx_now >= LOG_DEPTH);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (fail_tally < 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin : watch
    icr_pkg::icr_result_t want;
    if (!rst_n) begin
      restart_session(icr_pkg::MODE_OFF);
      for (int i = 0; i < LOG_DEPTH; i++) begin
        tape_pos[ADDR_W'(i)]    = '0;
        tape_button[ADDR_W'(i)] = '0;
        tape_key[ADDR_W'(i)]    = '0;
        tape_frame[ADDR_W'(i)]  = '0;
      end
      awaited_words.delete();
    end else begin
      // compare first: a result never belongs to a word taken at the same edge
      if (out_valid && !out_stall) begin
        if (awaited_words.size() == 0) begin
          if (fail_tally < 10)
            $display("result %0d arrived with nothing awaited", results_seen);
          fail_tally++;
        end else begin
          want = awaited_words.pop_front();
          check_field("joystick_pos_out", 16'(want.pos), 16'(out_joystick_pos_out));
          check_field("joystick_button_out", 16'(want.button),
                      16'(out_joystick_button_out));
          check_field("key_out", want.key, out_key_out);
          check_field("entry_logged", 16'(want.logged), 16'(out_entry_logged));
          check_field("entry_replayed", 16'(want.replayed), 16'(out_entry_replayed));
          check_field("log_full", 16'(want.full), 16'(out_log_full));
          logged_tally   += int'(want.logged);
          replayed_tally += int'(want.replayed);
          full_tally     += int'(want.full);
        end
        results_seen++;
      end
      if (in_valid && !in_stall)
        awaited_words.push_back(replay_result(in_action, in_new_mode, in_joystick_pos,
                                              in_joystick_button, in_key_code));
    end
    mismatches     <= fail_tally;
    awaited_count  <= awaited_words.size();
    logged_count   <= logged_tally;
    replayed_count <= replayed_tally;
    full_count     <= full_tally;
  end

endmodule

@@ tb/sv/input_change_recorder_replayer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_change_recorder_replayer_test
// Drives the recorder and replayer with a directed opening and then random
// sessions: record followed by playback, playback of whatever the log holds,
// off and spare-mode runs, and noise. One session fills the log to its depth
// under a long receiver hold-off and replays the start of it. Both channels
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module input_change_recorder_replayer_test;

  localparam int LOG_DEPTH   = 1024;
  localparam int FRAME_BITS  = 32;
  localparam int TOTAL_WORDS = 1700;
  localparam int FILL_AFTER  = 250;
  localparam int FILL_REPLAY = 128;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 800000;

  // unused mode code; the block treats it as off
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [1:0]  in_new_mode;
  logic [7:0]  in_joystick_pos;
  logic [7:0]  in_joystick_button;
  logic [15:0] in_key_code;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_joystick_pos_out;
  logic [7:0]  out_joystick_button_out;
  logic [15:0] out_key_out;
  logic        out_entry_logged;
  logic        out_entry_replayed;
  logic        out_log_full;

  int mismatches;
  int awaited_count;
  int logged_count;
  int replayed_count;
  int full_count;

  int          words_sent    = 0;
  int          cycles        = 0;
  bit          no_gaps       = 1'b1;
  logic        long_hold_req = 1'b0;
  logic [7:0]  cur_pos       = 8'hff;
  logic [7:0]  cur_btn       = 8'hff;
  logic [15:0] cur_key       = 16'hffff;

  input_change_recorder_replayer #(
    .LOG_DEPTH (LOG_DEPTH),
    .FRAME_BITS(FRAME_BITS)
  ) uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_new_mode            (in_new_mode),
    .in_joystick_pos        (in_joystick_pos),
    .in_joystick_button     (in_joystick_button),
    .in_key_code            (in_key_code),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_joystick_pos_out   (out_joystick_pos_out),
    .out_joystick_button_out(out_joystick_button_out),
    .out_key_out            (out_key_out),
    .out_entry_logged       (out_entry_logged),
    .out_entry_replayed     (out_entry_replayed),
    .out_log_full           (out_log_full)
  );

  input_change_checker #(
    .LOG_DEPTH (LOG_DEPTH),
    .FRAME_BITS(FRAME_BITS)
  ) watcher (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_new_mode            (in_new_mode),
    .in_joystick_pos        (in_joystick_pos),
    .in_joystick_button     (in_joystick_button),
    .in_key_code            (in_key_code),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_joystick_pos_out   (out_joystick_pos_out),
    .out_joystick_button_out(out_joystick_button_out),
    .out_key_out            (out_key_out),
    .out_entry_logged       (out_entry_logged),
    .out_entry_replayed     (out_entry_replayed),
    .out_log_full           (out_log_full),
    .mismatches             (mismatches),
    .awaited_count          (awaited_count),
    .logged_count           (logged_count),
    .replayed_count         (replayed_count),
    .full_count             (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles without finishing", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len(input bit none);
    int r;
    r = $urandom_range(0, 99);
    if (none || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : receiver
    int n;
    bit calm;
    bit held_long;
    calm      = 1'b0;
    held_long = 1'b0;
    forever begin
      if (long_hold_req && !held_long) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if ($urandom_range(0, 49) == 0) calm = !calm;
        n = idle_len(calm);
        out_stall <= (n != 0);
        if (n == 0) n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic act, input logic [1:0] nm, input logic [7:0] p,
                           input logic [7:0] b, input logic [15:0] k);
    int gap;
    gap = idle_len(no_gaps);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_new_mode        <= nm;
    in_joystick_pos    <= p;
    in_joystick_button <= b;
    in_key_code        <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // new_mode is don't-care on a tick, so let it wander
  task automatic tick(input logic [7:0] p, input logic [7:0] b, input logic [15:0] k);
    send_word(icr_pkg::ACT_TICK, 2'($urandom_range(0, 3)), p, b, k);
  endtask

  task automatic tick_random();
    tick(8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic set_mode(input logic [1:0] m);
    send_word(icr_pkg::ACT_SET_MODE, m, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Hold the input in 45 of 100 calls, otherwise change one field or all.
  task automatic drift_input();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return;
    if (r < 53) cur_pos = 8'($urandom);
    else if (r < 61) cur_btn = 8'($urandom);
    else if (r < 69) cur_key = 16'($urandom);
    else if (r < 77) begin
      cur_pos = icr_pkg::LAST_BYTE_INIT;
      cur_btn = icr_pkg::LAST_BYTE_INIT;
      cur_key = icr_pkg::LAST_KEY_INIT;
    end else begin
      {cur_pos, cur_btn, cur_key} = $urandom;
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  initial begin : stimulus
    int pick;
    int n;
    bit filled;
    logic [31:0] w;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_action          <= icr_pkg::ACT_TICK;
    in_new_mode        <= icr_pkg::MODE_OFF;
    in_joystick_pos    <= '0;
    in_joystick_button <= '0;
    in_key_code        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // off and spare mode pass the live word through
    tick(8'h00, 8'h00, 16'h0000);
    tick(8'hff, 8'hff, 16'hffff);
    set_mode(MODE_SPARE);
    tick(8'h5a, 8'hc3, 16'h8001);
    // record: the restart value is not a change, then a change of all fields and single-field changes
    set_mode(icr_pkg::MODE_RECORD);
    tick(8'hff, 8'hff, 16'hffff);
    tick(8'h00, 8'h00, 16'h0000);
    tick(8'h00, 8'h00, 16'h0000);
    tick(8'h00, 8'h80, 16'h0000);
    tick(8'h00, 8'h80, 16'hffff);
    tick(8'h80, 8'h80, 16'hffff);
    tick(8'h80, 8'h80, 16'hffff);
    // playback: entries come back on frames 1, 3, 4 and 5
    set_mode(icr_pkg::MODE_PLAYBACK);
    repeat (7) tick_random();
    set_mode(icr_pkg::MODE_OFF);
    tick(8'h7f, 8'h01, 16'h7ffe);
    wait_all_results();

    filled  = 1'b0;
    no_gaps = 1'b0;
    while (words_sent < TOTAL_WORDS) begin
      if (!filled && words_sent > FILL_AFTER) begin
        filled  = 1'b1;
        no_gaps = 1'b1;
        wait_all_results();
        // fill the log past its depth under a long receiver hold-off
        set_mode(icr_pkg::MODE_RECORD);
        long_hold_req <= 1'b1;
        for (n = 0; n < LOG_DEPTH + 6; n++) begin
          w = $urandom;
          if (w == {cur_pos, cur_btn, cur_key}) w[0] = ~w[0];
          {cur_pos, cur_btn, cur_key} = w;
          tick(cur_pos, cur_btn, cur_key);
        end
        set_mode(icr_pkg::MODE_PLAYBACK);
        for (n = 0; n < FILL_REPLAY; n++) tick_random();
      end else begin
        pick    = $urandom_range(0, 99);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (pick < 45) begin
          set_mode(icr_pkg::MODE_RECORD);
          n = $urandom_range(4, 60);
          repeat (n) begin
            drift_input();
            tick(cur_pos, cur_btn, cur_key);
          end
          set_mode(icr_pkg::MODE_PLAYBACK);
          repeat (n + $urandom_range(0, 20)) tick_random();
        end else if (pick < 65) begin
          // replay whatever earlier sessions left in the store
          set_mode(icr_pkg::MODE_PLAYBACK);
          repeat ($urandom_range(4, 60)) tick_random();
        end else if (pick < 80) begin
          set_mode(pick < 72 ? icr_pkg::MODE_OFF : MODE_SPARE);
          repeat ($urandom_range(2, 20)) tick_random();
        end else begin
          repeat ($urandom_range(5, 30))
            send_word($urandom_range(0, 4) == 0, 2'($urandom_range(0, 3)),
                      8'($urandom), 8'($urandom), 16'($urandom));
        end
      end
      if ($urandom_range(0, 9) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    $display("%0d words over off, spare, record and playback sessions, one full log",
             words_sent);
    $display("results with an entry logged %0d, replayed %0d, log full %0d",
             logged_count, replayed_count, full_count);
    if (mismatches == 0 && awaited_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
